// File: src/dpcr_pkg.sv
// shared types and constants for the disc pair collision pipeline
// depends on nothing; every other file refers to it by scoped names
package dpcr_pkg;

  localparam int ROOT_STEPS = 32;

  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_PUSH = 2'd1;
  localparam logic [1:0] OUT_SWAP = 2'd2;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic        [30:0] first_radius;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
    logic        [30:0] second_radius;
  } pair_t;

  typedef struct packed {
    logic        [1:0]  outcome;
    logic signed [31:0] new_first_pos_x;
    logic signed [31:0] new_first_pos_y;
    logic signed [31:0] new_first_vel_x;
    logic signed [31:0] new_first_vel_y;
    logic signed [31:0] new_second_pos_x;
    logic signed [31:0] new_second_pos_y;
    logic signed [31:0] new_second_vel_x;
    logic signed [31:0] new_second_vel_y;
  } res_t;

  // per-pair data carried alongside the square root and divider
  typedef struct packed {
    pair_t       pair;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        negx;
    logic        negy;
    logic [31:0] md;
    logic        contact;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// File: src/dpcr_if.sv
// valid/ready channel interfaces for pairs in and results out
// depends on dpcr_pkg
interface dpcr_pair_if;
  logic            valid;
  logic            ready;
  dpcr_pkg::pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpcr_res_if;
  logic           valid;
  logic           ready;
  dpcr_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/dpcr_front.sv
// front stages: centre differences, squares and the contact test
// depends on dpcr_pkg
module dpcr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vld_in,
  input  dpcr_pkg::pair_t   pair_in,
  output logic              vld_out,
  output logic [63:0]       sq_out,
  output dpcr_pkg::side_t   side_out
);

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [32:0]        dx_mag;
  logic [32:0]        dy_mag;
  logic [64:0]        sq_sum;

  logic            a_vld;
  dpcr_pkg::side_t a_side;
  logic            b_vld;
  dpcr_pkg::side_t b_side;
  logic [63:0]     b_sx;
  logic [63:0]     b_sy;
  logic [63:0]     b_mdsq;
  logic            c_vld;
  dpcr_pkg::side_t c_side;
  dpcr_pkg::side_t c_side_next;
  logic [63:0]     c_sq;

  always_comb begin
    dx = 33'(pair_in.second_pos_x) - 33'(pair_in.first_pos_x);
    dy = 33'(pair_in.second_pos_y) - 33'(pair_in.first_pos_y);
    dx_mag = dx[32] ? 33'(-dx) : 33'(dx);
    dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
    sq_sum = 65'(b_sx) + 65'(b_sy);
    c_side_next = b_side;
    c_side_next.contact = (sq_sum < {1'b0, b_mdsq}) && (sq_sum != 65'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      a_vld <= vld_in;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.pair    <= pair_in;
      a_side.ax      <= dx_mag[31:0];
      a_side.ay      <= dy_mag[31:0];
      a_side.negx    <= dx[32];
      a_side.negy    <= dy[32];
      a_side.md      <= 32'(pair_in.first_radius) + 32'(pair_in.second_radius);
      a_side.contact <= 1'b0;
      b_side <= a_side;
      b_sx   <= a_side.ax * a_side.ax;
      b_sy   <= a_side.ay * a_side.ay;
      b_mdsq <= a_side.md * a_side.md;
      c_side <= c_side_next;
      c_sq   <= sq_sum[63:0];
    end
  end

  assign vld_out  = c_vld;
  assign sq_out   = c_sq;
  assign side_out = c_side;

endmodule

// File: src/dpcr_root.sv
// integer square root, one result bit per pipeline stage
// depends on dpcr_pkg
module dpcr_root (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  logic [63:0]     sq_in,
  input  dpcr_pkg::side_t side_in,
  output logic            vld_out,
  output logic [31:0]     dist_val,
  output dpcr_pkg::side_t side_out
);

  localparam int NS = dpcr_pkg::ROOT_STEPS;

  logic [NS-1:0]   vld;
  logic [33:0]     rem   [NS];
  logic [31:0]     root  [NS];
  logic [63:0]     sq    [NS];
  dpcr_pkg::side_t side  [NS];

  logic [33:0] rem_in  [NS];
  logic [31:0] root_in [NS];
  logic [63:0] sq_in_s [NS];
  logic [35:0] cur     [NS];
  logic [35:0] trial   [NS];
  logic        take    [NS];

  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    sq_in_s[0] = sq_in;
    for (int k = 1; k < NS; k++) begin
      rem_in[k]  = rem[k-1];
      root_in[k] = root[k-1];
      sq_in_s[k] = sq[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      cur[k]   = {rem_in[k], sq_in_s[k][63:62]};
      trial[k] = {2'b00, root_in[k], 2'b01};
      take[k]  = cur[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        rem[k]  <= take[k] ? 34'(cur[k] - trial[k]) : cur[k][33:0];
        root[k] <= {root_in[k][30:0], take[k]};
        sq[k]   <= {sq_in_s[k][61:0], 2'b00};
      end
      side[0] <= side_in;
      for (int k = 1; k < NS; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign vld_out  = vld[NS-1];
  assign dist_val = root[NS-1];
  assign side_out = side[NS-1];

endmodule

// File: src/dpcr_div.sv
// restoring divider for both normal components, one quotient bit per stage
// depends on dpcr_pkg
module dpcr_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [31:0]          dist_in,
  input  dpcr_pkg::side_t      side_in,
  output logic                 vld_out,
  output logic [FRAC_BITS:0]   qx,
  output logic [FRAC_BITS:0]   qy,
  output logic [31:0]          dist_out,
  output dpcr_pkg::side_t      side_out
);

  localparam int DS = FRAC_BITS + 1;

  logic [DS-1:0]   vld;
  logic [31:0]     rem  [DS][2];
  logic [DS-1:0]   quo  [DS][2];
  logic [31:0]     dvs  [DS];
  dpcr_pkg::side_t side [DS];

  logic [31:0]   rem_in [DS][2];
  logic [DS-1:0] quo_in [DS][2];
  logic [31:0]   dvs_in [DS];
  logic          nbit   [DS][2];
  logic [32:0]   trial  [DS][2];
  logic          take   [DS][2];

  always_comb begin
    rem_in[0][0] = {1'b0, side_in.ax[31:1]};
    rem_in[0][1] = {1'b0, side_in.ay[31:1]};
    nbit[0][0]   = side_in.ax[0];
    nbit[0][1]   = side_in.ay[0];
    quo_in[0][0] = '0;
    quo_in[0][1] = '0;
    dvs_in[0]    = dist_in;
    for (int k = 1; k < DS; k++) begin
      dvs_in[k] = dvs[k-1];
      for (int a = 0; a < 2; a++) begin
        rem_in[k][a] = rem[k-1][a];
        quo_in[k][a] = quo[k-1][a];
        nbit[k][a]   = 1'b0;
      end
    end
    for (int k = 0; k < DS; k++) begin
      for (int a = 0; a < 2; a++) begin
        trial[k][a] = {rem_in[k][a], nbit[k][a]};
        take[k][a]  = trial[k][a] >= {1'b0, dvs_in[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DS-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DS; k++) begin
        dvs[k] <= dvs_in[k];
        for (int a = 0; a < 2; a++) begin
          rem[k][a] <= take[k][a] ? 32'(trial[k][a] - {1'b0, dvs_in[k]})
                                  : trial[k][a][31:0];
          quo[k][a] <= {quo_in[k][a][DS-2:0], take[k][a]};
        end
      end
      side[0] <= side_in;
      for (int k = 1; k < DS; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign vld_out  = vld[DS-1];
  assign qx       = quo[DS-1][0];
  assign qy       = quo[DS-1][1];
  assign dist_out = dvs[DS-1];
  assign side_out = side[DS-1];

endmodule

// File: src/dpcr_back.sv
// back stages: push apart, normal velocity exchange, saturation, output register
// depends on dpcr_pkg
module dpcr_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_in,
  input  logic [FRAC_BITS:0] qx,
  input  logic [FRAC_BITS:0] qy,
  input  logic [31:0]        dist_val,
  input  dpcr_pkg::side_t    side_in,
  output logic               out_vld,
  output dpcr_pkg::res_t     out_data
);

  localparam int NW  = FRAC_BITS + 2;
  localparam int MW  = NW + 33;
  localparam int DTW = MW + 1;
  localparam int VW  = 36;
  localparam int IW  = NW + VW;

  // stage 0
  logic                   b0_vld;
  dpcr_pkg::side_t        b0_side;
  logic signed [NW-1:0]   b0_n  [2];
  logic [31:0]            b0_ov;
  logic signed [32:0]     b0_dv [2];
  // stage 1
  logic                   b1_vld;
  dpcr_pkg::side_t        b1_side;
  logic signed [NW-1:0]   b1_n  [2];
  logic signed [MW-1:0]   b1_pp [2];
  logic signed [MW-1:0]   b1_dp [2];
  // stage 2
  logic                   b2_vld;
  dpcr_pkg::side_t        b2_side;
  logic signed [NW-1:0]   b2_n    [2];
  logic signed [32:0]     b2_push [2];
  logic signed [VW-1:0]   b2_van;
  logic                   b2_swap;
  // stage 3
  logic                   b3_vld;
  dpcr_pkg::side_t        b3_side;
  logic signed [IW-1:0]   b3_ip  [2];
  logic signed [31:0]     b3_np1 [2];
  logic signed [31:0]     b3_np2 [2];
  logic                   b3_swap;

  logic [FRAC_BITS:0]     q    [2];
  logic                   neg  [2];
  logic signed [NW-1:0]   nq   [2];
  logic signed [32:0]     dv   [2];
  logic [MW-1:0]          pp_mag [2];
  logic [MW-1:0]          pp_sh  [2];
  logic [MW-1:0]          pp_t   [2];
  logic signed [DTW-1:0]  dot;
  logic [DTW-1:0]         dot_mag;
  logic [DTW-1:0]         dot_sh;
  logic [DTW-1:0]         dot_t;
  logic signed [31:0]     p1_3 [2];
  logic signed [31:0]     p2_3 [2];
  logic [IW-1:0]          ip_mag [2];
  logic [IW-1:0]          ip_sh  [2];
  logic [IW-1:0]          ip_t   [2];
  logic signed [VW-1:0]   ix     [2];
  logic signed [31:0]     v1_4   [2];
  logic signed [31:0]     v2_4   [2];
  logic signed [31:0]     nv1    [2];
  logic signed [31:0]     nv2    [2];
  logic [1:0]             outcome;

  always_comb begin
    q[0]   = qx;
    q[1]   = qy;
    neg[0] = side_in.negx;
    neg[1] = side_in.negy;
    dv[0]  = 33'(side_in.pair.second_vel_x) - 33'(side_in.pair.first_vel_x);
    dv[1]  = 33'(side_in.pair.second_vel_y) - 33'(side_in.pair.first_vel_y);
    for (int a = 0; a < 2; a++) begin
      nq[a] = neg[a] ? NW'(-$signed({1'b0, q[a]})) : $signed({1'b0, q[a]});
    end

    for (int a = 0; a < 2; a++) begin
      pp_mag[a] = b1_pp[a][MW-1] ? MW'(-b1_pp[a]) : MW'(b1_pp[a]);
      pp_sh[a]  = pp_mag[a] >> (FRAC_BITS + 1);
      pp_t[a]   = b1_pp[a][MW-1] ? MW'(-pp_sh[a]) : pp_sh[a];
    end
    dot     = DTW'(b1_dp[0]) + DTW'(b1_dp[1]);
    dot_mag = dot[DTW-1] ? DTW'(-dot) : DTW'(dot);
    dot_sh  = dot_mag >> FRAC_BITS;
    dot_t   = dot[DTW-1] ? DTW'(-dot_sh) : dot_sh;

    p1_3[0] = b2_side.pair.first_pos_x;
    p1_3[1] = b2_side.pair.first_pos_y;
    p2_3[0] = b2_side.pair.second_pos_x;
    p2_3[1] = b2_side.pair.second_pos_y;

    v1_4[0] = b3_side.pair.first_vel_x;
    v1_4[1] = b3_side.pair.first_vel_y;
    v2_4[0] = b3_side.pair.second_vel_x;
    v2_4[1] = b3_side.pair.second_vel_y;
    for (int a = 0; a < 2; a++) begin
      ip_mag[a] = b3_ip[a][IW-1] ? IW'(-b3_ip[a]) : IW'(b3_ip[a]);
      ip_sh[a]  = ip_mag[a] >> FRAC_BITS;
      ip_t[a]   = b3_ip[a][IW-1] ? IW'(-ip_sh[a]) : ip_sh[a];
      ix[a]     = ip_t[a][VW-1:0];
      nv1[a]    = dpcr_pkg::sat32(40'(v1_4[a]) + 40'(ix[a]));
      nv2[a]    = dpcr_pkg::sat32(40'(v2_4[a]) - 40'(ix[a]));
    end
    if (!b3_side.contact) begin
      outcome = dpcr_pkg::OUT_NONE;
    end else if (b3_swap) begin
      outcome = dpcr_pkg::OUT_SWAP;
    end else begin
      outcome = dpcr_pkg::OUT_PUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_vld  <= 1'b0;
      b1_vld  <= 1'b0;
      b2_vld  <= 1'b0;
      b3_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      b0_vld  <= vld_in;
      b1_vld  <= b0_vld;
      b2_vld  <= b1_vld;
      b3_vld  <= b2_vld;
      out_vld <= b3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_side <= side_in;
      b0_ov   <= side_in.md - dist_val;
      for (int a = 0; a < 2; a++) begin
        b0_n[a]  <= nq[a];
        b0_dv[a] <= dv[a];
      end

      b1_side <= b0_side;
      for (int a = 0; a < 2; a++) begin
        b1_n[a]  <= b0_n[a];
        b1_pp[a] <= MW'(b0_n[a]) * MW'($signed({1'b0, b0_ov}));
        b1_dp[a] <= MW'(b0_n[a]) * MW'(b0_dv[a]);
      end

      b2_side <= b1_side;
      b2_van  <= dot_t[VW-1:0];
      b2_swap <= dot[DTW-1] || (dot == '0);
      for (int a = 0; a < 2; a++) begin
        b2_n[a]    <= b1_n[a];
        b2_push[a] <= pp_t[a][32:0];
      end

      b3_side <= b2_side;
      b3_swap <= b2_swap;
      for (int a = 0; a < 2; a++) begin
        b3_ip[a]  <= IW'(b2_n[a]) * IW'(b2_van);
        b3_np1[a] <= dpcr_pkg::sat32(40'(p1_3[a]) - 40'(b2_push[a]));
        b3_np2[a] <= dpcr_pkg::sat32(40'(p2_3[a]) + 40'(b2_push[a]));
      end

      out_data.outcome <= outcome;
      if (b3_side.contact) begin
        out_data.new_first_pos_x  <= b3_np1[0];
        out_data.new_first_pos_y  <= b3_np1[1];
        out_data.new_second_pos_x <= b3_np2[0];
        out_data.new_second_pos_y <= b3_np2[1];
      end else begin
        out_data.new_first_pos_x  <= b3_side.pair.first_pos_x;
        out_data.new_first_pos_y  <= b3_side.pair.first_pos_y;
        out_data.new_second_pos_x <= b3_side.pair.second_pos_x;
        out_data.new_second_pos_y <= b3_side.pair.second_pos_y;
      end
      if (b3_side.contact && b3_swap) begin
        out_data.new_first_vel_x  <= nv1[0];
        out_data.new_first_vel_y  <= nv1[1];
        out_data.new_second_vel_x <= nv2[0];
        out_data.new_second_vel_y <= nv2[1];
      end else begin
        out_data.new_first_vel_x  <= v1_4[0];
        out_data.new_first_vel_y  <= v1_4[1];
        out_data.new_second_vel_x <= v2_4[0];
        out_data.new_second_vel_y <= v2_4[1];
      end
    end
  end

endmodule

// File: src/disc_pair_collision_resolve.sv
// channel    role    payload
// pair       sink    two discs: centre, velocity and radius of each, Q16.16
// res        source  outcome and updated centres and velocities, saturated
//
// one pair per cycle while the output register is taken; the front, square root, divider
// and back stages follow in that order, and the square root stage chain holds most of them
// rst clears every valid bit; payload registers are not reset
// the whole pipeline holds while the output register is full and not taken
// depends on dpcr_pkg, dpcr_if, dpcr_front, dpcr_root, dpcr_div, dpcr_back
module disc_pair_collision_resolve #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  dpcr_pair_if.sink   pair,
  dpcr_res_if.source  res
);

  logic               adv;
  logic               f_vld;
  logic [63:0]        f_sq;
  dpcr_pkg::side_t    f_side;
  logic               r_vld;
  logic [31:0]        r_dist;
  dpcr_pkg::side_t    r_side;
  logic               d_vld;
  logic [FRAC_BITS:0] d_qx;
  logic [FRAC_BITS:0] d_qy;
  logic [31:0]        d_dist;
  dpcr_pkg::side_t    d_side;

  assign adv        = !res.valid || res.ready;
  assign pair.ready = adv;

  dpcr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (pair.valid),
    .pair_in  (pair.data),
    .vld_out  (f_vld),
    .sq_out   (f_sq),
    .side_out (f_side)
  );

  dpcr_root u_root (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (f_vld),
    .sq_in    (f_sq),
    .side_in  (f_side),
    .vld_out  (r_vld),
    .dist_val (r_dist),
    .side_out (r_side)
  );

  dpcr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (r_vld),
    .dist_in  (r_dist),
    .side_in  (r_side),
    .vld_out  (d_vld),
    .qx       (d_qx),
    .qy       (d_qy),
    .dist_out (d_dist),
    .side_out (d_side)
  );

  dpcr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (d_vld),
    .qx       (d_qx),
    .qy       (d_qy),
    .dist_val (d_dist),
    .side_in  (d_side),
    .out_vld  (res.valid),
    .out_data (res.data)
  );

  a_root_hold: assert property (@(posedge clk) disable iff (rst)
    !adv && r_vld |=> r_vld)
    else $error("stalled transaction lost at square root output");

  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    !adv && d_vld |=> d_vld && $stable(d_qx) && $stable(d_qy))
    else $error("stalled transaction changed at divider output");

  a_outcome: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.outcome == dpcr_pkg::OUT_NONE ||
                   res.data.outcome == dpcr_pkg::OUT_PUSH ||
                   res.data.outcome == dpcr_pkg::OUT_SWAP))
    else $error("bad outcome code");

endmodule

// File: bench/tb_disc_pair_collision_resolve.sv
// testbench for disc_pair_collision_resolve: drives disc pairs, predicts each result
// in a scoreboard class and checks every output transaction in order
// depends on dpcr_pkg, dpcr_if and the block under test
`timescale 1ns / 1ps

module tb_disc_pair_collision_resolve;

  localparam int FRAC = 16;
  localparam int NUM_RANDOM = 1750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = FRAC + 41 + 40;
  localparam int HOLD_START = 1200;
  localparam int HOLD_LEN = 400;

  logic clk;
  logic rst;
  int unsigned cycles = 0;
  bit no_idle;

  dpcr_pair_if pair ();
  dpcr_res_if res ();

  disc_pair_collision_resolve #(.FRAC_BITS(FRAC)) u_top (
    .clk  (clk),
    .rst  (rst),
    .pair (pair.sink),
    .res  (res.source)
  );

  class collision_scoreboard;
    dpcr_pkg::res_t pending[$];
    int errors;
    int checked;
    int hits[3];

    static function longint trunc_shr(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = m >>> s;
      return (v < 0) ? -m : m;
    endfunction

    static function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    static function longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function dpcr_pkg::res_t resolve_pair(dpcr_pkg::pair_t p);
      dpcr_pkg::res_t o;
      longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
      longint dx, dy, nx, ny, ov, pushx, pushy, dot, van, ix, iy;
      longint unsigned ax, ay, md, dlen, qx, qy;
      logic [65:0] sq;
      logic [65:0] lim;
      p1x = p.first_pos_x;  p1y = p.first_pos_y;
      v1x = p.first_vel_x;  v1y = p.first_vel_y;
      p2x = p.second_pos_x; p2y = p.second_pos_y;
      v2x = p.second_vel_x; v2y = p.second_vel_y;
      md = longint'(p.first_radius) + longint'(p.second_radius);
      dx = p2x - p1x;
      dy = p2y - p1y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sq = {2'b00, ax} * {2'b00, ax} + {2'b00, ay} * {2'b00, ay};
      lim = {2'b00, md} * {2'b00, md};
      o.outcome = dpcr_pkg::OUT_NONE;
      if (sq != 0 && sq < lim) begin
        dlen = int_root(sq[63:0]);
        qx = (ax << FRAC) / dlen;
        qy = (ay << FRAC) / dlen;
        nx = (dx < 0) ? -longint'(qx) : longint'(qx);
        ny = (dy < 0) ? -longint'(qy) : longint'(qy);
        ov = md - dlen;
        pushx = trunc_shr(nx * ov, FRAC + 1);
        pushy = trunc_shr(ny * ov, FRAC + 1);
        p1x -= pushx; p1y -= pushy;
        p2x += pushx; p2y += pushy;
        o.outcome = dpcr_pkg::OUT_PUSH;
        dot = nx * (v2x - v1x) + ny * (v2y - v1y);
        if (dot <= 0) begin
          van = trunc_shr(dot, FRAC);
          ix = trunc_shr(nx * van, FRAC);
          iy = trunc_shr(ny * van, FRAC);
          v1x += ix; v1y += iy;
          v2x -= ix; v2y -= iy;
          o.outcome = dpcr_pkg::OUT_SWAP;
        end
      end
      o.new_first_pos_x = clamp32(p1x);
      o.new_first_pos_y = clamp32(p1y);
      o.new_first_vel_x = clamp32(v1x);
      o.new_first_vel_y = clamp32(v1y);
      o.new_second_pos_x = clamp32(p2x);
      o.new_second_pos_y = clamp32(p2y);
      o.new_second_vel_x = clamp32(v2x);
      o.new_second_vel_y = clamp32(v2y);
      return o;
    endfunction

    function void note_pair(dpcr_pkg::pair_t p);
      dpcr_pkg::res_t e;
      e = resolve_pair(p);
      hits[e.outcome]++;
      pending.push_back(e);
    endfunction

    task report(string field, longint got, longint want);
      errors++;
      $display("mismatch at result %0d: %s got %0d expected %0d", checked, field, got, want);
    endtask

    task check_result(dpcr_pkg::res_t got);
      dpcr_pkg::res_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (got.outcome !== e.outcome) report("outcome", got.outcome, e.outcome);
      if (got.new_first_pos_x !== e.new_first_pos_x)
        report("new_first_pos_x", got.new_first_pos_x, e.new_first_pos_x);
      if (got.new_first_pos_y !== e.new_first_pos_y)
        report("new_first_pos_y", got.new_first_pos_y, e.new_first_pos_y);
      if (got.new_first_vel_x !== e.new_first_vel_x)
        report("new_first_vel_x", got.new_first_vel_x, e.new_first_vel_x);
      if (got.new_first_vel_y !== e.new_first_vel_y)
        report("new_first_vel_y", got.new_first_vel_y, e.new_first_vel_y);
      if (got.new_second_pos_x !== e.new_second_pos_x)
        report("new_second_pos_x", got.new_second_pos_x, e.new_second_pos_x);
      if (got.new_second_pos_y !== e.new_second_pos_y)
        report("new_second_pos_y", got.new_second_pos_y, e.new_second_pos_y);
      if (got.new_second_vel_x !== e.new_second_vel_x)
        report("new_second_vel_x", got.new_second_vel_x, e.new_second_vel_x);
      if (got.new_second_vel_y !== e.new_second_vel_y)
        report("new_second_vel_y", got.new_second_vel_y, e.new_second_vel_y);
      checked++;
    endtask
  endclass

  collision_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) sb.check_result(res.data);
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int n;
    n = 0;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (n >= HOLD_START && n < HOLD_START + HOLD_LEN) res.ready = 1'b0;
      else if (no_idle) res.ready = 1'b1;
      else res.ready = ($urandom_range(99) >= 22);
      n++;
      @(negedge clk);
    end
  end

  function automatic dpcr_pkg::pair_t mk(int p1x, int p1y, int v1x, int v1y, int r1,
                                         int p2x, int p2y, int v2x, int v2y, int r2);
    dpcr_pkg::pair_t p;
    p.first_pos_x = p1x;  p.first_pos_y = p1y;
    p.first_vel_x = v1x;  p.first_vel_y = v1y;
    p.first_radius = r1[30:0];
    p.second_pos_x = p2x; p.second_pos_y = p2y;
    p.second_vel_x = v2x; p.second_vel_y = v2y;
    p.second_radius = r2[30:0];
    return p;
  endfunction

  function automatic dpcr_pkg::pair_t random_noise();
    dpcr_pkg::pair_t p;
    p.first_pos_x = $urandom;  p.first_pos_y = $urandom;
    p.first_vel_x = $urandom;  p.first_vel_y = $urandom;
    p.first_radius = 31'($urandom);
    p.second_pos_x = $urandom; p.second_pos_y = $urandom;
    p.second_vel_x = $urandom; p.second_vel_y = $urandom;
    p.second_radius = 31'($urandom);
    return p;
  endfunction

  // near pair at a random scale, mostly in contact
  function automatic dpcr_pkg::pair_t random_contact();
    dpcr_pkg::pair_t p;
    int s;
    logic [31:0] mask;
    logic [31:0] vmask;
    s = $urandom_range(2, 30);
    mask = (32'd1 << s) - 1;
    vmask = ($urandom_range(9) < 3) ? 32'hffffffff : ((32'd1 << $urandom_range(2, 31)) - 1);
    p = random_noise();
    p.second_pos_x = p.first_pos_x + int'($urandom & mask) - int'(mask >> 1);
    p.second_pos_y = p.first_pos_y + int'($urandom & mask) - int'(mask >> 1);
    p.first_radius = ($urandom_range(9) == 0) ? mask[30:0] : 31'($urandom & mask);
    p.second_radius = 31'($urandom & mask);
    p.first_vel_x = int'($urandom & vmask) - int'(vmask >> 1);
    p.first_vel_y = int'($urandom & vmask) - int'(vmask >> 1);
    p.second_vel_x = int'($urandom & vmask) - int'(vmask >> 1);
    p.second_vel_y = int'($urandom & vmask) - int'(vmask >> 1);
    return p;
  endfunction

  task automatic send_pair(dpcr_pkg::pair_t p);
    int gap;
    gap = (!no_idle && $urandom_range(99) < 22) ? $urandom_range(1, 5) : 0;
    repeat (gap) begin
      pair.valid = 1'b0;
      @(negedge clk);
    end
    pair.valid = 1'b1;
    pair.data = p;
    @(posedge clk);
    while (!pair.ready) @(posedge clk);
    sb.note_pair(p);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pair.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    dpcr_pkg::pair_t dir[$];
    int one;
    one = 1 << FRAC;
    no_idle = 1'b0;
    pair.valid = 1'b0;
    pair.data = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(5, 7, 1, 2, one, 5, 7, 3, 4, one));
    dir.push_back(mk(0, 0, 0, 0, one, 10 * one, 0, 0, 0, one));
    dir.push_back(mk(0, 0, one, 0, one, one, 0, -one, 0, one));
    dir.push_back(mk(0, 0, -one, 0, one, one, 0, one, 0, one));
    dir.push_back(mk(0, 0, 3 * one, -one, one, one, one, 3 * one, -one, one));
    dir.push_back(mk(one, -one, 0, one, 2 * one, 2 * one, 0, one, -one, one));
    dir.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff));
    dir.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h80000001, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
    dir.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                     32'h7ffffffe, 32'h7ffffff0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    dir.push_back(mk(-1, -1, -1, -1, 32'h7fffffff, -1, -1, -1, -1, 32'h7fffffff));
    dir.push_back(mk(0, 0, 0, 0, 0, 1, 0, 0, 0, 2));
    dir.push_back(mk(0, 0, 0, one, one, 0, one, 0, -one, one));
    dir.push_back(mk(0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 32'h7fffffff));
    foreach (dir[i]) send_pair(dir[i]);
    wait_drained();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      no_idle = (i >= 1300 && i < 1600);
      if (i == 900) wait_drained();
      send_pair(($urandom_range(99) < 80) ? random_contact() : random_noise());
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("checked %0d results: %0d apart, %0d pushed, %0d exchanged", sb.checked,
             sb.hits[dpcr_pkg::OUT_NONE], sb.hits[dpcr_pkg::OUT_PUSH],
             sb.hits[dpcr_pkg::OUT_SWAP]);
    $display("directed extremes, saturation, coincident and near-contact random pairs");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
